@@ src/ttf_pkg.sv @@
`default_nettype none
package ttf_pkg;

   localparam int POSITION_BITS_DEF = 32;
   localparam int PosFieldW = 32;
   localparam int TexW = 20;
   localparam int EdgeW = 33;
   localparam int TexDW = 21;
   localparam int ProdW = 54;
   localparam int AccW = 55;
   localparam int MagW = 56;
   localparam int SqW = 60;
   localparam int RootW = 63;
   localparam int LenW = 32;
   localparam int RemW = 47;
   localparam int OutW = 16;
   localparam int QBits = 16;

   typedef struct packed {
      logic [2:0][EdgeW-1:0] e1;
      logic [2:0][EdgeW-1:0] e2;
      logic [TexDW-1:0] du1;
      logic [TexDW-1:0] dv1;
      logic [TexDW-1:0] du2;
      logic [TexDW-1:0] dv2;
   } job_type;

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_MUL  = 10'b0000000010,
      S_SIGN = 10'b0000000100,
      S_LOAD = 10'b0000001000,
      S_NORM = 10'b0000010000,
      S_SQ   = 10'b0000100000,
      S_SQRT = 10'b0001000000,
      S_DLD  = 10'b0010000000,
      S_DIV  = 10'b0100000000,
      S_DONE = 10'b1000000000
   } state_type;

endpackage
`default_nettype wire

@@ src/ttf_front.sv @@
`default_nettype none
module ttf_front import ttf_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [135:0] req_tdata,
   output logic              job_valid,
   input  wire logic         job_ready,
   output job_type           job
);

   localparam int PosW = (POSITION_BITS < PosFieldW) ? POSITION_BITS : PosFieldW;
   localparam int Sh = PosFieldW - PosW;

   logic [1:0] slot_ff, slot_in;
   logic [2:0][PosFieldW-1:0] p0_ff, p1_ff;
   logic [TexW-1:0] u0_ff, v0_ff, u1_ff, v1_ff;
   logic [2:0][PosFieldW-1:0] pin, p0s, p1s, p2s;
   logic accept;

   function automatic logic [PosFieldW-1:0] sx(input logic [PosFieldW-1:0] v);
      logic [PosFieldW-1:0] t;
      t = v << Sh;
      return PosFieldW'($signed(t) >>> Sh);
   endfunction

   assign pin[0] = req_tdata[31:0];
   assign pin[1] = req_tdata[63:32];
   assign pin[2] = req_tdata[95:64];

   assign req_tready = (slot_ff != 2'd2) || job_ready;
   assign job_valid = req_tvalid && (slot_ff == 2'd2);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      slot_in = slot_ff;
      if (accept) begin
         slot_in = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 2'd0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && slot_ff == 2'd0) begin
         p0_ff <= pin;
         u0_ff <= req_tdata[115:96];
         v0_ff <= req_tdata[135:116];
      end
      if (accept && slot_ff == 2'd1) begin
         p1_ff <= pin;
         u1_ff <= req_tdata[115:96];
         v1_ff <= req_tdata[135:116];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p0s[i] = sx(p0_ff[i]);
         p1s[i] = sx(p1_ff[i]);
         p2s[i] = sx(pin[i]);
         job.e1[i] = {p1s[i][31], p1s[i]} - {p0s[i][31], p0s[i]};
         job.e2[i] = {p2s[i][31], p2s[i]} - {p0s[i][31], p0s[i]};
      end
      job.du1 = {u1_ff[19], u1_ff} - {u0_ff[19], u0_ff};
      job.dv1 = {v1_ff[19], v1_ff} - {v0_ff[19], v0_ff};
      job.du2 = {req_tdata[115], req_tdata[115:96]} - {u0_ff[19], u0_ff};
      job.dv2 = {req_tdata[135], req_tdata[135:116]} - {v0_ff[19], v0_ff};
   end

endmodule
`default_nettype wire

@@ src/ttf_queue.sv @@
`default_nettype none
module ttf_queue import ttf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire job_type in_job,
   output logic         out_valid,
   input  wire logic    out_ready,
   output job_type      out_job
);

   job_type mem_ff [2];
   logic wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job = mem_ff[rptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= in_job;
      end
   end

endmodule
`default_nettype wire

@@ src/ttf_back.sv @@
`default_nettype none
module ttf_back import ttf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   output logic         job_ready,
   input  wire job_type job,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output logic [95:0]  rsp_tdata,
   output logic         rsp_tuser
);

   state_type state_ff, state_in;
   logic rvalid_ff, rvalid_in;
   job_type job_ff, job_in;
   logic [3:0] cnt_ff, cnt_in;
   logic ph_ff, ph_in;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic signed [AccW-1:0] det_ff, det_in;
   logic signed [AccW-1:0] t_ff [3], t_in [3], b_ff [3], b_in [3];
   logic negdet_ff, negdet_in, vsel_ff, vsel_in, deg_ff, deg_in;
   logic [MagW-1:0] m_ff [3], m_in [3];
   logic [2:0] neg_ff, neg_in;
   logic [1:0] k_ff, k_in;
   logic [SqW-1:0] sq_ff, sq_in;
   logic [RootW-1:0] l_ff, l_in, x_ff, x_in, r_ff, r_in, bit_ff, bit_in;
   logic [LenW-1:0] len_ff, len_in;
   logic [RemW-1:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QBits-1:0] q_ff, q_in;
   logic [OutW-1:0] tr_ff [3], tr_in [3], br_ff [3], br_in [3];
   logic [95:0] data_ff, data_in;
   logic user_ff, user_in;

   logic signed [TexDW-1:0] op_a;
   logic signed [EdgeW-1:0] op_b;
   logic [3:0] c2;
   logic [1:0] vi;
   logic signed [AccW-1:0] vsrc [3];
   logic signed [MagW-1:0] vext [3], vadj [3];
   logic [MagW-1:0] mx_a, mx;
   logic [RootW-1:0] rb;
   logic [OutW-1:0] qres;
   logic [QBits-1:0] qn;

   assign job_ready = (state_ff == S_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tuser = user_ff;

   always_comb begin
      c2 = cnt_ff - 4'd2;
      vi = c2[3:2];
      op_a = $signed(job_ff.du1);
      op_b = EdgeW'($signed(job_ff.dv2));
      if (cnt_ff == 4'd1) begin
         op_a = $signed(job_ff.du2);
         op_b = EdgeW'($signed(job_ff.dv1));
      end else if (cnt_ff != 4'd0) begin
         case (c2[1:0])
            2'd0: begin op_a = $signed(job_ff.dv2); op_b = $signed(job_ff.e1[vi]); end
            2'd1: begin op_a = $signed(job_ff.dv1); op_b = $signed(job_ff.e2[vi]); end
            2'd2: begin op_a = $signed(job_ff.du1); op_b = $signed(job_ff.e2[vi]); end
            default: begin op_a = $signed(job_ff.du2); op_b = $signed(job_ff.e1[vi]); end
         endcase
      end
      for (int i = 0; i < 3; i++) begin
         vsrc[i] = vsel_ff ? b_ff[i] : t_ff[i];
         vext[i] = MagW'(vsrc[i]);
         vadj[i] = negdet_ff ? -vext[i] : vext[i];
      end
      mx_a = (m_ff[0] > m_ff[1]) ? m_ff[0] : m_ff[1];
      mx = (mx_a > m_ff[2]) ? mx_a : m_ff[2];
      rb = r_ff + bit_ff;
      qn = {q_ff[QBits-2:0], (rem_ff >= dsh_ff)};
      qres = neg_ff[k_ff] ? -qn : qn;
   end

   always_comb begin
      state_in = state_ff;
      rvalid_in = rvalid_ff;
      job_in = job_ff;
      cnt_in = cnt_ff;
      ph_in = ph_ff;
      prod_in = prod_ff;
      det_in = det_ff;
      t_in = t_ff;
      b_in = b_ff;
      negdet_in = negdet_ff;
      vsel_in = vsel_ff;
      deg_in = deg_ff;
      m_in = m_ff;
      neg_in = neg_ff;
      k_in = k_ff;
      sq_in = sq_ff;
      l_in = l_ff;
      x_in = x_ff;
      r_in = r_ff;
      bit_in = bit_ff;
      len_in = len_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in = q_ff;
      tr_in = tr_ff;
      br_in = br_ff;
      data_in = data_ff;
      user_in = user_ff;
      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_in = job;
               cnt_in = 4'd0;
               ph_in = 1'b0;
               deg_in = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (!ph_ff) begin
               prod_in = ProdW'(op_a * op_b);
               ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               if (cnt_ff == 4'd0) begin
                  det_in = AccW'(prod_ff);
               end else if (cnt_ff == 4'd1) begin
                  det_in = det_ff - AccW'(prod_ff);
               end else begin
                  case (c2[1:0])
                     2'd0: t_in[vi] = AccW'(prod_ff);
                     2'd1: t_in[vi] = t_ff[vi] - AccW'(prod_ff);
                     2'd2: b_in[vi] = AccW'(prod_ff);
                     default: b_in[vi] = b_ff[vi] - AccW'(prod_ff);
                  endcase
               end
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd13) begin
                  state_in = S_SIGN;
               end
            end
         end
         S_SIGN: begin
            negdet_in = det_ff[AccW-1];
            vsel_in = 1'b0;
            if (det_ff == '0) begin
               deg_in = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = vadj[i][MagW-1];
               m_in[i] = vadj[i][MagW-1] ? MagW'(-vadj[i]) : MagW'(vadj[i]);
            end
            if (vsrc[0] == '0 && vsrc[1] == '0 && vsrc[2] == '0) begin
               deg_in = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (mx[MagW-1:30] != '0) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] >> 1;
            end else if (!mx[29]) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] << 1;
            end else begin
               l_in = '0;
               k_in = 2'd0;
               ph_in = 1'b0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (!ph_ff) begin
               sq_in = m_ff[k_ff][29:0] * m_ff[k_ff][29:0];
               ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               l_in = l_ff + RootW'(sq_ff);
               k_in = k_ff + 2'd1;
               if (k_ff == 2'd2) begin
                  x_in = l_ff + RootW'(sq_ff);
                  r_in = '0;
                  bit_in = RootW'(1) << (RootW - 1);
                  state_in = S_SQRT;
               end
            end
         end
         S_SQRT: begin
            if (x_ff >= rb) begin
               x_in = x_ff - rb;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == RootW'(1)) begin
               len_in = r_in[LenW-1:0];
               k_in = 2'd0;
               state_in = S_DLD;
            end
         end
         S_DLD: begin
            rem_in = RemW'({m_ff[k_ff][29:0], 14'd0}) + RemW'(len_ff >> 1);
            dsh_in = {len_ff[LenW-1:0], 15'd0};
            q_in = '0;
            cnt_in = 4'd0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
            end
            dsh_in = dsh_ff >> 1;
            q_in = qn;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               if (vsel_ff) begin
                  br_in[k_ff] = qres;
               end else begin
                  tr_in[k_ff] = qres;
               end
               k_in = k_ff + 2'd1;
               if (k_ff != 2'd2) begin
                  state_in = S_DLD;
               end else if (!vsel_ff) begin
                  vsel_in = 1'b1;
                  state_in = S_LOAD;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_DIV;
            end
         end
         S_DONE: begin
            if (!rvalid_ff || rsp_tready) begin
               rvalid_in = 1'b1;
               user_in = deg_ff;
               if (deg_ff) begin
                  data_in = '0;
               end else begin
                  data_in = {br_ff[2], br_ff[1], br_ff[0], tr_ff[2], tr_ff[1], tr_ff[0]};
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      cnt_ff <= cnt_in;
      ph_ff <= ph_in;
      prod_ff <= prod_in;
      det_ff <= det_in;
      t_ff <= t_in;
      b_ff <= b_in;
      negdet_ff <= negdet_in;
      vsel_ff <= vsel_in;
      deg_ff <= deg_in;
      m_ff <= m_in;
      neg_ff <= neg_in;
      k_ff <= k_in;
      sq_ff <= sq_in;
      l_ff <= l_in;
      x_ff <= x_in;
      r_ff <= r_in;
      bit_ff <= bit_in;
      len_ff <= len_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff <= q_in;
      tr_ff <= tr_in;
      br_ff <= br_in;
      data_ff <= data_in;
      user_ff <= user_in;
   end

endmodule
`default_nettype wire

@@ src/triangle_tangent_frame.sv @@
`default_nettype none
// Tangent frame of a triangle from its positions and texture coordinates. Vertices
// come in one per item, three to a triangle. The front end takes a vertex every
// cycle while the two-deep queue has room. It holds the first two vertices and, on
// the third, passes the edge and UV deltas into the queue. For a triangle with a
// usable frame, the back end first computes fourteen products through one
// multiplier, each registered and then accumulated. Then, for each vector, it does
// one-bit normalizing shifts, forms the squared length, takes the square root and
// runs three 16-step divisions. A zero determinant or tangent ends the work right
// after the products, and a zero bitangent once the tangent is done. A result
// waiting on rsp_tready holds the back end. One result item per triangle: unit
// tangent and bitangent in Q1.14, or zeros with the degenerate flag in tuser when
// the UV determinant or either vector is zero.
module triangle_tangent_frame import ttf_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [135:0] req_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [95:0]       rsp_tdata,  // tangent_x/y/z, bitangent_x/y/z
   output logic              rsp_tuser   // degenerate
);

   logic f_valid, f_ready, b_valid, b_ready;
   job_type f_job, b_job;

   ttf_front #(.POSITION_BITS(POSITION_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   ttf_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
   );

   ttf_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

endmodule
`default_nettype wire
